// ----- hdl/sdr_pkg.sv -----
// Shared types, constants and codes for the SD SPI single-block read engine.
`default_nettype none
package sdr_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int BC_W = ($clog2(BLOCK_BYTES) > 3) ? $clog2(BLOCK_BYTES) : 3;
	localparam int POLL_W = 20;
	localparam int CFG_W = 20;
	localparam int REG_IDX_W = 2;

	localparam logic [7:0] FILLER = 8'hFF;
	localparam logic [7:0] CMD_PREFIX = 8'h40;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [BC_W-1:0] FRAME_LAST = BC_W'(6);

	localparam logic [5:0] RST_CMD_INDEX = 6'd17;
	localparam logic [7:0] RST_CMD_CRC = 8'd0;
	localparam logic [7:0] RST_RESP_LIMIT = 8'd10;
	localparam logic [POLL_W-1:0] RST_TOKEN_LIMIT = POLL_W'(100000);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FRAME,
		PH_RESP,
		PH_TOKEN,
		PH_DATA,
		PH_CRC
	} phase_t;

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_BYTE  = 1'b1
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CMD_INDEX,
		REG_CMD_CRC,
		REG_RESP_LIMIT,
		REG_TOKEN_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [0:0]  command;
		logic [31:0] block_address;
		logic [7:0]  rx_byte;
	} req_word_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic        last_data;
		logic        done_res;
		logic        status;
		logic [7:0]  card_response;
		logic [15:0] crc_value;
	} res_word_t;

	typedef struct packed {
		logic [5:0]        cmd_index;
		logic [7:0]        cmd_crc;
		logic [7:0]        resp_limit;
		logic [POLL_W-1:0] token_limit;
	} cfg_t;

endpackage
`default_nettype wire

// ----- hdl/sdr_req_if.sv -----
// Request channel: start commands and received link bytes.
`default_nettype none
interface sdr_req_if;
	logic               valid;
	logic               ready;
	sdr_pkg::req_word_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/sdr_res_if.sv -----
// Result channel: bytes to send, block data and completion status.
`default_nettype none
interface sdr_res_if;
	logic               valid;
	logic               ready;
	sdr_pkg::res_word_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- hdl/sdr_cfg_regs.sv -----
// Configuration register file for the block read engine.
`default_nettype none
module sdr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [sdr_pkg::REG_IDX_W-1:0]  reg_index,
	input  wire logic [sdr_pkg::CFG_W-1:0]      wr_data,
	output sdr_pkg::cfg_t                       cfg
);

	sdr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_index   <= sdr_pkg::RST_CMD_INDEX;
			cfg_q.cmd_crc     <= sdr_pkg::RST_CMD_CRC;
			cfg_q.resp_limit  <= sdr_pkg::RST_RESP_LIMIT;
			cfg_q.token_limit <= sdr_pkg::RST_TOKEN_LIMIT;
		end else if (wr_en) begin
			case (sdr_pkg::reg_idx_t'(reg_index))
				sdr_pkg::REG_CMD_INDEX: begin
					cfg_q.cmd_index <= wr_data[5:0];
				end
				sdr_pkg::REG_CMD_CRC: begin
					cfg_q.cmd_crc <= wr_data[7:0];
				end
				sdr_pkg::REG_RESP_LIMIT: begin
					cfg_q.resp_limit <= wr_data[7:0];
				end
				sdr_pkg::REG_TOKEN_LIMIT: begin
					cfg_q.token_limit <= wr_data[sdr_pkg::POLL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- hdl/sdr_engine.sv -----
// Transaction state and per-word step logic: framing, polling, data and CRC.
`default_nettype none
module sdr_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire sdr_pkg::req_word_t  word,
	input  wire sdr_pkg::cfg_t       cfg,
	output logic                     has_res,
	output sdr_pkg::res_word_t       res_word
);

	localparam int BC_W = sdr_pkg::BC_W;
	localparam int POLL_W = sdr_pkg::POLL_W;

	sdr_pkg::phase_t     phase_q, nxt_phase;
	logic [BC_W-1:0]     byte_cnt_q, nxt_byte_cnt;
	logic [POLL_W-1:0]   poll_cnt_q, nxt_poll_cnt;
	logic [15:0]         crc_q, nxt_crc;
	logic [31:0]         addr_q, nxt_addr;
	logic [7:0]          resp_q, nxt_resp;

	logic                do_decide;
	logic                do_data;
	logic [BC_W-1:0]     bc_inc;
	logic [BC_W:0]       bc_wide_inc;
	logic [15:0]         crc_fold_res;

	function automatic logic [15:0] crc_fold(input logic [15:0] acc_in, input logic [7:0] b);
		logic [15:0] acc;
		acc = acc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (acc[15])
				acc = {acc[14:0], 1'b0} ^ sdr_pkg::CRC_POLY;
			else
				acc = {acc[14:0], 1'b0};
		end
		return acc;
	endfunction

	assign bc_inc = byte_cnt_q + BC_W'(1);
	assign bc_wide_inc = {1'b0, byte_cnt_q} + (BC_W+1)'(1);
	assign crc_fold_res = crc_fold(crc_q, word.rx_byte);

	always_comb begin
		nxt_phase    = phase_q;
		nxt_byte_cnt = byte_cnt_q;
		nxt_poll_cnt = poll_cnt_q;
		nxt_crc      = crc_q;
		nxt_addr     = addr_q;
		nxt_resp     = resp_q;
		res_word     = '0;
		has_res      = 1'b0;
		do_decide    = 1'b0;
		do_data      = 1'b0;

		if (word.command == sdr_pkg::CMD_START) begin
			nxt_addr     = word.block_address;
			nxt_resp     = sdr_pkg::FILLER;
			nxt_phase    = sdr_pkg::PH_FRAME;
			nxt_byte_cnt = '0;
			nxt_poll_cnt = '0;
			nxt_crc      = '0;
			has_res      = 1'b1;
			res_word.tx_valid = 1'b1;
			res_word.tx_byte  = sdr_pkg::FILLER;
		end else begin
			case (phase_q)
				sdr_pkg::PH_FRAME: begin
					has_res = 1'b1;
					if (byte_cnt_q < sdr_pkg::FRAME_LAST) begin
						nxt_byte_cnt = bc_inc;
						res_word.tx_valid = 1'b1;
						case (bc_inc[2:0])
							3'd1:    res_word.tx_byte = sdr_pkg::CMD_PREFIX | {2'b00, cfg.cmd_index};
							3'd2:    res_word.tx_byte = addr_q[31:24];
							3'd3:    res_word.tx_byte = addr_q[23:16];
							3'd4:    res_word.tx_byte = addr_q[15:8];
							3'd5:    res_word.tx_byte = addr_q[7:0];
							default: res_word.tx_byte = cfg.cmd_crc;
						endcase
					end else if (cfg.resp_limit == 8'd0) begin
						do_decide = 1'b1;
					end else begin
						nxt_poll_cnt = '0;
						nxt_phase    = sdr_pkg::PH_RESP;
						res_word.tx_valid = 1'b1;
						res_word.tx_byte  = sdr_pkg::FILLER;
					end
				end
				sdr_pkg::PH_RESP: begin
					has_res      = 1'b1;
					nxt_poll_cnt = poll_cnt_q + POLL_W'(1);
					nxt_resp     = word.rx_byte;
					if (word.rx_byte != sdr_pkg::FILLER ||
							nxt_poll_cnt >= POLL_W'(cfg.resp_limit)) begin
						do_decide = 1'b1;
					end else begin
						res_word.tx_valid = 1'b1;
						res_word.tx_byte  = sdr_pkg::FILLER;
					end
				end
				sdr_pkg::PH_TOKEN: begin
					has_res      = 1'b1;
					nxt_poll_cnt = poll_cnt_q + POLL_W'(1);
					if (word.rx_byte != sdr_pkg::FILLER || nxt_poll_cnt >= cfg.token_limit) begin
						do_data = 1'b1;
					end else begin
						res_word.tx_valid = 1'b1;
						res_word.tx_byte  = sdr_pkg::FILLER;
					end
				end
				sdr_pkg::PH_DATA: begin
					has_res = 1'b1;
					nxt_crc = crc_fold_res;
					res_word.data_valid = 1'b1;
					res_word.data_byte  = word.rx_byte;
					if (bc_wide_inc >= (BC_W+1)'(sdr_pkg::BLOCK_BYTES)) begin
						res_word.last_data = 1'b1;
						nxt_phase    = sdr_pkg::PH_CRC;
						nxt_byte_cnt = '0;
					end else begin
						nxt_byte_cnt = bc_inc;
					end
					res_word.tx_valid = 1'b1;
					res_word.tx_byte  = sdr_pkg::FILLER;
				end
				sdr_pkg::PH_CRC: begin
					has_res = 1'b1;
					nxt_crc = crc_fold_res;
					if (byte_cnt_q == '0) begin
						nxt_byte_cnt = BC_W'(1);
						res_word.tx_valid = 1'b1;
						res_word.tx_byte  = sdr_pkg::FILLER;
					end else begin
						nxt_phase = sdr_pkg::PH_IDLE;
						res_word.done_res  = 1'b1;
						res_word.status    = 1'b0;
						res_word.crc_value = crc_fold_res;
					end
				end
				default: begin
					has_res = 1'b0;
				end
			endcase
		end

		// response byte decides between reject, token wait and data start
		if (do_decide) begin
			nxt_resp = word.rx_byte;
			if (word.rx_byte != 8'h00) begin
				nxt_phase = sdr_pkg::PH_IDLE;
				res_word.done_res = 1'b1;
				res_word.status   = 1'b1;
			end else begin
				nxt_poll_cnt = '0;
				if (cfg.token_limit == '0) begin
					do_data = 1'b1;
				end else begin
					nxt_phase = sdr_pkg::PH_TOKEN;
					res_word.tx_valid = 1'b1;
					res_word.tx_byte  = sdr_pkg::FILLER;
				end
			end
		end

		if (do_data) begin
			nxt_phase    = sdr_pkg::PH_DATA;
			nxt_byte_cnt = '0;
			nxt_crc      = '0;
			res_word.tx_valid = 1'b1;
			res_word.tx_byte  = sdr_pkg::FILLER;
		end

		res_word.card_response = nxt_resp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= sdr_pkg::PH_IDLE;
			byte_cnt_q <= '0;
			poll_cnt_q <= '0;
			crc_q      <= '0;
			addr_q     <= '0;
			resp_q     <= sdr_pkg::FILLER;
		end else if (step) begin
			phase_q    <= nxt_phase;
			byte_cnt_q <= nxt_byte_cnt;
			poll_cnt_q <= nxt_poll_cnt;
			crc_q      <= nxt_crc;
			addr_q     <= nxt_addr;
			resp_q     <= nxt_resp;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sd_spi_block_read.sv -----
// Top level of the SD card SPI single-block read engine.
//
// req carries one word per SPI byte exchange: command 0 starts a read of
// block_address (abandoning any read in progress), command 1 hands in the
// byte received for the byte last sent. A received byte while idle is
// dropped and gives no result.
// res carries at most one word per step: the next byte to send (tx_valid/tx_byte),
// a block data byte (data_valid/data_byte/last_data), and on the final word
// done_res with status (1 = rejected by card) and crc_value (0 = good).
// The user must write registers on wr_en/reg_index/wr_data only while the
// engine idles; the block does not enforce it. A word accepted on req is
// registered in word_s1, then stepped into res_word_q once res is free.
// Throughput: one word per cycle while res is not stalled; the step logic
// (frame mux, poll compare, byte-wide CRC-16 fold) sits between the input
// and result registers. A stalled res holds its word; req keeps taking one
// more word and then drops ready until the result register drains. Reset
// clears both pipeline registers, the engine goes idle and the registers
// return to their defaults; no clearing pass is needed.
`default_nettype none
module sd_spi_block_read (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	sdr_req_if.sink                            req,
	sdr_res_if.source                          res,
	input  wire logic                          wr_en,
	input  wire logic [sdr_pkg::REG_IDX_W-1:0] reg_index,
	input  wire logic [sdr_pkg::CFG_W-1:0]     wr_data
);

	sdr_pkg::cfg_t       cfg;
	logic                valid_s1;
	sdr_pkg::req_word_t  word_s1;
	logic                res_valid_q;
	sdr_pkg::res_word_t  res_word_q;
	logic                res_free;
	logic                step;
	logic                has_res;
	sdr_pkg::res_word_t  step_res;

	sdr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data),
		.cfg       (cfg)
	);

	sdr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.word     (word_s1),
		.cfg      (cfg),
		.has_res  (has_res),
		.res_word (step_res)
	);

	assign res_free  = !res_valid_q || res.ready;
	assign step      = valid_s1 && res_free;
	assign req.ready = !valid_s1 || res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			word_s1 <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= step && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_res) begin
			res_word_q <= step_res;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_word_q;

	a_data_sends: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.data_valid |-> res.payload.tx_valid)
		else $error("data word without a filler to send");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.done_res |-> !res.payload.tx_valid && !res.payload.data_valid)
		else $error("completion word also sends or carries data");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.payload.status || res.payload.crc_value != 16'h0000)
		|-> res.payload.done_res)
		else $error("status or crc outside completion word");

	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.payload.last_data |-> res.payload.data_valid)
		else $error("last_data without data_valid");

endmodule
`default_nettype wire

// ----- tb/sv/tb_sd_spi_block_read.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the SD SPI single-block read engine.
module tb_sd_spi_block_read;
	import sdr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE = 8;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_IDX_W-1:0] reg_index;
	logic [CFG_W-1:0] wr_data;

	sdr_req_if req_if();
	sdr_res_if res_if();

	sd_spi_block_read u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if),
		.wr_en(wr_en),
		.reg_index(reg_index),
		.wr_data(wr_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	req_word_t link_words[$];
	res_word_t expected_link[$];
	bit idle_on = 1'b1;
	int cycles = 0;
	int mismatches = 0;
	int n_sent = 0;
	int n_queued = 0;
	int n_checked = 0;
	int n_data = 0;
	int n_good = 0;
	int n_rejected = 0;

	// engine state as the card link sees it
	cfg_t eng_cfg;
	phase_t eng_phase;
	int eng_bytes;
	logic [POLL_W-1:0] eng_polls;
	logic [15:0] eng_crc;
	logic [31:0] eng_addr;
	logic [7:0] eng_resp;

	function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic void begin_data(inout res_word_t r);
		eng_phase = PH_DATA;
		eng_bytes = 0;
		eng_crc = '0;
		r.tx_valid = 1'b1;
		r.tx_byte = FILLER;
	endfunction

	function automatic void judge_response(inout res_word_t r, input logic [7:0] b);
		eng_resp = b;
		if (b != 8'h00) begin
			eng_phase = PH_IDLE;
			r.done_res = 1'b1;
			r.status = 1'b1;
		end else begin
			eng_polls = '0;
			if (eng_cfg.token_limit == '0) begin
				begin_data(r);
			end else begin
				eng_phase = PH_TOKEN;
				r.tx_valid = 1'b1;
				r.tx_byte = FILLER;
			end
		end
	endfunction

	function automatic bit predict_link_step(input req_word_t w, output res_word_t r);
		r = '0;
		if (w.command == CMD_START) begin
			eng_addr = w.block_address;
			eng_resp = FILLER;
			eng_phase = PH_FRAME;
			eng_bytes = 0;
			eng_polls = '0;
			eng_crc = '0;
			r.tx_valid = 1'b1;
			r.tx_byte = FILLER;
			r.card_response = eng_resp;
			return 1'b1;
		end
		case (eng_phase)
			PH_FRAME: begin
				if (eng_bytes < 6) begin
					eng_bytes++;
					r.tx_valid = 1'b1;
					case (eng_bytes)
						1: r.tx_byte = CMD_PREFIX | {2'b00, eng_cfg.cmd_index};
						2: r.tx_byte = eng_addr[31:24];
						3: r.tx_byte = eng_addr[23:16];
						4: r.tx_byte = eng_addr[15:8];
						5: r.tx_byte = eng_addr[7:0];
						default: r.tx_byte = eng_cfg.cmd_crc;
					endcase
				end else if (eng_cfg.resp_limit == 8'd0) begin
					judge_response(r, w.rx_byte);
				end else begin
					eng_polls = '0;
					eng_phase = PH_RESP;
					r.tx_valid = 1'b1;
					r.tx_byte = FILLER;
				end
			end
			PH_RESP: begin
				eng_polls = eng_polls + 1'b1;
				eng_resp = w.rx_byte;
				if (w.rx_byte != FILLER || eng_polls >= POLL_W'(eng_cfg.resp_limit)) begin
					judge_response(r, w.rx_byte);
				end else begin
					r.tx_valid = 1'b1;
					r.tx_byte = FILLER;
				end
			end
			PH_TOKEN: begin
				eng_polls = eng_polls + 1'b1;
				if (w.rx_byte != FILLER || eng_polls >= eng_cfg.token_limit) begin
					begin_data(r);
				end else begin
					r.tx_valid = 1'b1;
					r.tx_byte = FILLER;
				end
			end
			PH_DATA: begin
				eng_crc = crc16_fold(eng_crc, w.rx_byte);
				r.data_valid = 1'b1;
				r.data_byte = w.rx_byte;
				if (eng_bytes + 1 >= BLOCK_BYTES) begin
					r.last_data = 1'b1;
					eng_phase = PH_CRC;
					eng_bytes = 0;
				end else begin
					eng_bytes++;
				end
				r.tx_valid = 1'b1;
				r.tx_byte = FILLER;
			end
			PH_CRC: begin
				eng_crc = crc16_fold(eng_crc, w.rx_byte);
				if (eng_bytes == 0) begin
					eng_bytes = 1;
					r.tx_valid = 1'b1;
					r.tx_byte = FILLER;
				end else begin
					eng_phase = PH_IDLE;
					r.done_res = 1'b1;
					r.status = 1'b0;
					r.crc_value = eng_crc;
				end
			end
			default: return 1'b0;
		endcase
		r.card_response = eng_resp;
		return 1'b1;
	endfunction

	task automatic queue_word(input cmd_t c, input logic [31:0] a, input logic [7:0] b);
		req_word_t w;
		w.command = c;
		w.block_address = a;
		w.rx_byte = b;
		link_words.push_back(w);
		n_queued++;
	endtask

	// one read from the card side: start, frame, response, token, data, CRC,
	// cut short or refused at random; only a full-block read carries the CRC
	task automatic queue_read(input bit full_block);
		int style;
		int rl;
		int tl;
		int polls;
		int n;
		logic [15:0] crc;
		logic [7:0] d;
		logic [31:0] a;
		req_word_t noise;
		rl = eng_cfg.resp_limit;
		tl = eng_cfg.token_limit;
		style = full_block ? $urandom_range(90, 99) : $urandom_range(99);
		case ($urandom_range(9))
			0: a = '0;
			1: a = '1;
			default: a = $urandom;
		endcase
		queue_word(CMD_START, a, 8'($urandom));
		if (style < 10) begin
			repeat ($urandom_range(6)) queue_word(CMD_BYTE, $urandom, 8'($urandom));
			return;
		end
		repeat (6) queue_word(CMD_BYTE, $urandom, 8'($urandom));
		if (rl != 0)
			queue_word(CMD_BYTE, $urandom, 8'($urandom));
		polls = (rl > 1) ? $urandom_range(rl > 4 ? 3 : rl - 1) : 0;
		if (style < 35) begin
			if (rl != 0 && rl <= 16 && $urandom_range(1) == 1)
				polls = rl;
			repeat (polls) queue_word(CMD_BYTE, $urandom, FILLER);
			if (polls < rl || rl == 0)
				queue_word(CMD_BYTE, $urandom, 8'($urandom_range(1, 255)));
			return;
		end
		repeat (polls) queue_word(CMD_BYTE, $urandom, FILLER);
		queue_word(CMD_BYTE, $urandom, 8'h00);
		if (tl != 0) begin
			if (tl <= 16 && $urandom_range(2) == 0) begin
				repeat (tl) queue_word(CMD_BYTE, $urandom, FILLER);
			end else begin
				repeat ($urandom_range(tl > 4 ? 4 : tl - 1))
					queue_word(CMD_BYTE, $urandom, FILLER);
				queue_word(CMD_BYTE, $urandom,
					($urandom_range(3) == 0) ? 8'($urandom_range(254)) : 8'hFE);
			end
		end
		n = full_block ? BLOCK_BYTES : $urandom_range(47);
		crc = '0;
		repeat (n) begin
			d = $urandom;
			crc = crc16_fold(crc, d);
			queue_word(CMD_BYTE, $urandom, d);
		end
		if (n < BLOCK_BYTES)
			return;
		if (style < 95) begin
			queue_word(CMD_BYTE, $urandom, crc[15:8]);
			queue_word(CMD_BYTE, $urandom, crc[7:0]);
		end else begin
			queue_word(CMD_BYTE, $urandom, 8'($urandom));
			queue_word(CMD_BYTE, $urandom, 8'($urandom));
		end
		// stray byte after the read ends: dropped by the idle engine
		if ($urandom_range(3) == 0) begin
			noise.command = CMD_BYTE;
			noise.block_address = $urandom;
			noise.rx_byte = $urandom;
			link_words.push_back(noise);
		end
	endtask

	task automatic drain_link();
		do
			@(posedge clk);
		while (link_words.size() != 0 || req_if.valid || expected_link.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] d);
		@(posedge clk);
		wr_en <= 1'b1;
		reg_index <= idx;
		wr_data <= d;
		case (idx)
			REG_CMD_INDEX: eng_cfg.cmd_index = d[5:0];
			REG_CMD_CRC: eng_cfg.cmd_crc = d[7:0];
			REG_RESP_LIMIT: eng_cfg.resp_limit = d[7:0];
			default: eng_cfg.token_limit = d[POLL_W-1:0];
		endcase
	endtask

	task automatic set_config(input logic [5:0] ci, input logic [7:0] cc,
			input logic [7:0] rl, input logic [POLL_W-1:0] tl);
		write_reg(REG_CMD_INDEX, CFG_W'(ci));
		write_reg(REG_CMD_CRC, CFG_W'(cc));
		write_reg(REG_RESP_LIMIT, CFG_W'(rl));
		write_reg(REG_TOKEN_LIMIT, CFG_W'(tl));
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic random_reads(input int budget, input bit with_full);
		int stop;
		stop = n_queued + budget;
		if (with_full)
			queue_read(1'b1);
		while (n_queued < stop)
			queue_read(1'b0);
		drain_link();
	endtask

	always @(posedge clk) begin : link_driver
		res_word_t nxt;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (req_if.valid) begin
				n_sent++;
				if (predict_link_step(req_if.payload, nxt))
					expected_link.push_back(nxt);
			end
			if (link_words.size() != 0 && !(idle_on && $urandom_range(99) < 29)) begin
				req_if.valid <= 1'b1;
				req_if.payload <= link_words.pop_front();
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_word_t want;
		res_word_t got;
		string bad;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
			if (res_if.valid && res_if.ready) begin
				got = res_if.payload;
				if (expected_link.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word with nothing expected: %h", got);
				end else begin
					want = expected_link.pop_front();
					bad = "";
					if (got.tx_valid !== want.tx_valid) bad = {bad, " tx_valid"};
					if (got.tx_byte !== want.tx_byte) bad = {bad, " tx_byte"};
					if (got.data_valid !== want.data_valid) bad = {bad, " data_valid"};
					if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
					if (got.last_data !== want.last_data) bad = {bad, " last_data"};
					if (got.done_res !== want.done_res) bad = {bad, " done_res"};
					if (got.status !== want.status) bad = {bad, " status"};
					if (got.card_response !== want.card_response) bad = {bad, " card_response"};
					if (got.crc_value !== want.crc_value) bad = {bad, " crc_value"};
					if (bad != "") begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d mismatch in%s", n_checked, bad);
							$display("  exp tx=%b/%h data=%b/%h last=%b done=%b st=%b resp=%h crc=%h",
								want.tx_valid, want.tx_byte, want.data_valid, want.data_byte,
								want.last_data, want.done_res, want.status,
								want.card_response, want.crc_value);
							$display("  got tx=%b/%h data=%b/%h last=%b done=%b st=%b resp=%h crc=%h",
								got.tx_valid, got.tx_byte, got.data_valid, got.data_byte,
								got.last_data, got.done_res, got.status,
								got.card_response, got.crc_value);
						end
					end
					n_checked++;
					if (want.data_valid) n_data++;
					if (want.done_res && !want.status) n_good++;
					if (want.done_res && want.status) n_rejected++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_link.size());
			$display("** sd_spi_block_read: FAILED **");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		reg_index = REG_CMD_INDEX;
		wr_data = '0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		res_if.ready = 1'b0;
		eng_cfg.cmd_index = RST_CMD_INDEX;
		eng_cfg.cmd_crc = RST_CMD_CRC;
		eng_cfg.resp_limit = RST_RESP_LIMIT;
		eng_cfg.token_limit = RST_TOKEN_LIMIT;
		eng_phase = PH_IDLE;
		eng_bytes = 0;
		eng_polls = '0;
		eng_crc = '0;
		eng_addr = '0;
		eng_resp = FILLER;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: stray byte, restart mid-frame, response polls run out
		queue_word(CMD_BYTE, 32'h0, 8'hA5);
		queue_word(CMD_START, 32'h0000_0000, 8'h00);
		queue_word(CMD_BYTE, 32'h0, 8'h00);
		queue_word(CMD_BYTE, 32'h0, 8'hFF);
		queue_word(CMD_START, 32'hFFFF_FFFF, 8'hFF);
		for (int i = 0; i < 6; i++)
			queue_word(CMD_BYTE, 32'hFFFF_FFFF, (i % 2) ? 8'hFF : 8'h00);
		queue_word(CMD_BYTE, 32'h0, 8'h5A);
		repeat (10) queue_word(CMD_BYTE, 32'h0, FILLER);
		queue_word(CMD_BYTE, 32'h0, 8'h00);
		drain_link();
		random_reads(560, 1'b1);

		set_config(6'd63, 8'hFF, 8'd255, 20'hFFFFF);
		random_reads(120, 1'b0);

		// zero limits: response taken at once, data starts at once
		set_config(6'd0, 8'h00, 8'd0, 20'd0);
		random_reads(120, 1'b0);

		set_config(6'($urandom), 8'($urandom), 8'd1, 20'd1);
		random_reads(80, 1'b0);

		idle_on = 1'b0;
		set_config(6'($urandom), 8'($urandom), 8'($urandom_range(2, 6)),
			20'($urandom_range(2, 8)));
		random_reads(180, 1'b0);
		repeat (SETTLE) @(posedge clk);

		$display("sent %0d words over five register settings; checked %0d results",
			n_sent, n_checked);
		$display("  %0d data bytes, %0d blocks finished, %0d reads refused",
			n_data, n_good, n_rejected);
		if (mismatches == 0 && expected_link.size() == 0)
			$display("** sd_spi_block_read: PASSED **");
		else
			$display("** sd_spi_block_read: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/sdr_pkg.sv
hdl/sdr_req_if.sv
hdl/sdr_res_if.sv
hdl/sdr_cfg_regs.sv
hdl/sdr_engine.sv
hdl/sd_spi_block_read.sv
tb/sv/tb_sd_spi_block_read.sv
